@@ rtl/core/scc_pkg.sv @@
// shared types and constants for the site composition counter
// no dependencies; imported by every module of the block except scc_div
package scc_pkg;

	localparam int OCC_W       = 3;
	localparam int COMP_W      = 3;
	localparam int NUM_MAPS    = 4;
	localparam int MAP_IDX_W   = 2;
	localparam int MAP_W       = 24;
	localparam int VOL_W       = 16;
	localparam int NCOMP_W     = 4;
	localparam int SUB_W       = 3;
	localparam int STORE_DEPTH = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int FRAC_BITS   = 16;
	localparam int MEAN_W      = 24;
	localparam int FRAC_W      = 17;
	localparam int CNT_OUT_W   = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP0,
		REG_MAP1,
		REG_MAP2,
		REG_MAP3,
		REG_SITES,
		REG_NCOMP,
		REG_VAC_EN,
		REG_VAC_COMP
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_MAPS-1:0][MAP_W-1:0] maps;
		logic [VOL_W-1:0]               sites;
		logic [NCOMP_W-1:0]             ncomp;
		logic                           vac_en;
		logic [COMP_W-1:0]              vac_comp;
	} cfg_t;

	// one classified site, front to back
	typedef struct packed {
		logic [COMP_W-1:0] comp;
		logic              counted;
		logic              past;
		logic              final_site;
	} site_entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_MEAN_GO,
		BK_MEAN_WAIT,
		BK_FRAC_GO,
		BK_FRAC_WAIT,
		BK_PUSH
	} back_state_t;

	// zero volume acts as one
	function automatic logic [VOL_W-1:0] vol_of(input cfg_t c);
		vol_of = (c.sites == '0) ? VOL_W'(1) : c.sites;
	endfunction

endpackage

@@ rtl/core/scc_if.sv @@
// valid/ready channel interfaces for site beats and result beats
// depends on scc_pkg for field widths
interface scc_in_if import scc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OCC_W-1:0] occupant;
	logic             final_site;

	modport source (output valid, output occupant, output final_site, input ready);
	modport sink   (input valid, input occupant, input final_site, output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [COMP_W-1:0]    component;
	logic [CNT_OUT_W-1:0] count;
	logic [MEAN_W-1:0]    mean_per_cell;
	logic [FRAC_W-1:0]    fraction;
	logic                 zero_total;
	logic                 overflow;
	logic                 last_result;

	modport source (output valid, output component, output count, output mean_per_cell,
		output fraction, output zero_total, output overflow, output last_result,
		input ready);
	modport sink   (input valid, input component, input count, input mean_per_cell,
		input fraction, input zero_total, input overflow, input last_result,
		output ready);
endinterface

@@ rtl/core/site_composition_counter.sv @@
// top level of the site composition counter: config registers, front, queue, back, divider
// depends on scc_pkg, scc_if, scc_queue, scc_front, scc_back, scc_div
//
// Use: site beats arrive on the sites channel, one occupant code each, sublattice
// blocks of sites_per_sublattice sites in order; final_site closes a run. The
// config port writes register cfg_index with cfg_data whenever cfg_write is high.
// Throughput: the front takes one site per cycle while the queue is not full and the
// back retires one queued site per cycle while it is counting, so a run streams at
// one site per cycle behind a 4-entry queue. After the final site the back sweeps
// the counts into the total, then per component runs the bit-serial divider for
// the mean and, unless the fraction is forced to zero, again for the fraction,
// then loads the result beat.
// The front keeps accepting the next run into the queue while results drain.
// Results sit in an output register; when the receiver stalls, the back holds
// its next result and then the queue fills, which drops ready on sites.
// Reset clears the counts, position, flags and queue and loads the register
// defaults; no clearing pass is needed.
module site_composition_counter import scc_pkg::*; #(
	parameter int MAX_SUBLATTICES = 4,
	parameter int MAX_COMPONENTS  = 8,
	parameter int COUNT_WIDTH     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scc_in_if.sink                sites,
	scc_out_if.source             results,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int SUB_LIMIT = (MAX_SUBLATTICES < NUM_MAPS) ? MAX_SUBLATTICES : NUM_MAPS;
	localparam int COMP_CAP  = (MAX_COMPONENTS < STORE_DEPTH) ? MAX_COMPONENTS : STORE_DEPTH;
	localparam int NUM_W     = COUNT_WIDTH + FRAC_BITS;
	localparam int TOT_W     = COUNT_WIDTH + $clog2(STORE_DEPTH);
	localparam int DEN_W     = (TOT_W > VOL_W) ? TOT_W : VOL_W;

	cfg_t             cfg_q;
	logic             q_full;
	logic             q_push;
	site_entry_t      q_in;
	logic             q_pop;
	logic             q_valid;
	site_entry_t      q_out;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_busy;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.maps     <= '0;
			cfg_q.sites    <= VOL_W'(1);
			cfg_q.ncomp    <= NCOMP_W'(1);
			cfg_q.vac_en   <= 1'b0;
			cfg_q.vac_comp <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAP0:     cfg_q.maps[0]  <= cfg_data[MAP_W-1:0];
				REG_MAP1:     cfg_q.maps[1]  <= cfg_data[MAP_W-1:0];
				REG_MAP2:     cfg_q.maps[2]  <= cfg_data[MAP_W-1:0];
				REG_MAP3:     cfg_q.maps[3]  <= cfg_data[MAP_W-1:0];
				REG_SITES:    cfg_q.sites    <= cfg_data[VOL_W-1:0];
				REG_NCOMP:    cfg_q.ncomp    <= cfg_data[NCOMP_W-1:0];
				REG_VAC_EN:   cfg_q.vac_en   <= cfg_data[0];
				REG_VAC_COMP: cfg_q.vac_comp <= cfg_data[COMP_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	scc_front #(
		.SUB_LIMIT (SUB_LIMIT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sites  (sites),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (q_push),
		.entry  (q_in)
	);

	scc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	scc_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	scc_back #(
		.COMP_CAP    (COMP_CAP),
		.COUNT_WIDTH (COUNT_WIDTH),
		.NUM_W       (NUM_W),
		.DEN_W       (DEN_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.pop       (q_pop),
		.div_start (div_start),
		.div_num   (div_num),
		.div_den   (div_den),
		.div_done  (div_done),
		.div_quot  (div_quot),
		.results   (results)
	);

	// the back never restarts the divider mid-division
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.fraction <= 17'd65536)
		else $error("fraction above one");

	a_zero_total: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.zero_total |-> results.fraction == '0)
		else $error("nonzero fraction with zero total");
endmodule

@@ rtl/core/scc_queue.sv @@
// short queue of classified sites between front and back
// depends on scc_pkg for the entry type
module scc_queue import scc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  site_entry_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output site_entry_t pop_data
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	site_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   fill_q;

	assign full      = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + (PTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (PTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule

@@ rtl/core/scc_front.sv @@
// front end: accepts site beats, tracks sublattice position, maps occupant to component
// depends on scc_pkg and scc_in_if; feeds scc_queue
module scc_front import scc_pkg::*; #(
	parameter int SUB_LIMIT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	scc_in_if.sink      sites,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        push,
	output site_entry_t entry
);
	logic [VOL_W-1:0] site_q;
	logic [SUB_W-1:0] sub_q;
	logic [VOL_W-1:0] vol;
	logic [VOL_W:0]   site_inc;
	logic             in_range;
	logic [MAP_W-1:0] map_word;

	assign sites.ready = !q_full;
	assign push        = sites.valid && !q_full;
	assign vol         = vol_of(cfg);
	assign site_inc    = {1'b0, site_q} + (VOL_W+1)'(1);
	assign in_range    = (sub_q < SUB_W'(SUB_LIMIT));
	assign map_word    = cfg.maps[sub_q[MAP_IDX_W-1:0]];

	always_comb begin
		entry.comp       = map_word[COMP_W*sites.occupant +: COMP_W];
		entry.counted    = in_range;
		entry.past       = !in_range;
		entry.final_site = sites.final_site;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_q <= '0;
			sub_q  <= '0;
		end else if (push) begin
			if (sites.final_site) begin
				site_q <= '0;
				sub_q  <= '0;
			end else if (in_range) begin
				if (site_inc >= {1'b0, vol}) begin
					site_q <= '0;
					sub_q  <= sub_q + SUB_W'(1);
				end else begin
					site_q <= site_inc[VOL_W-1:0];
				end
			end
		end
	end
endmodule

@@ rtl/core/scc_div.sv @@
// restoring divider, one quotient bit per cycle
// no package dependency; shared by mean and fraction computation
module scc_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign fits    = (shifted >= {1'b0, den_q});
	assign busy    = busy_q;
	assign done    = done_q;
	// quotient bits shift in from the bottom as numerator bits leave the top
	assign quot    = num_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ rtl/core/scc_back.sv @@
// back end: counts classified sites, then sums, normalizes and emits one beat per component
// depends on scc_pkg, scc_out_if; drives the shared scc_div
module scc_back import scc_pkg::*; #(
	parameter int COMP_CAP    = 8,
	parameter int COUNT_WIDTH = 16,
	parameter int NUM_W       = 32,
	parameter int DEN_W       = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_valid,
	input  site_entry_t      q_data,
	output logic             pop,
	output logic             div_start,
	output logic [NUM_W-1:0] div_num,
	output logic [DEN_W-1:0] div_den,
	input  logic             div_done,
	input  logic [NUM_W-1:0] div_quot,
	scc_out_if.source        results
);
	localparam int TOT_W = COUNT_WIDTH + $clog2(STORE_DEPTH);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	back_state_t             st_q, st_d;
	logic [COUNT_WIDTH-1:0]  counts_q [STORE_DEPTH];
	logic [COMP_W-1:0]       k_q;
	logic [TOT_W-1:0]        total_q;
	logic                    ovf_q;
	logic [MEAN_W-1:0]       mean_q;
	logic [FRAC_W-1:0]       frac_q;

	logic                    out_valid_q;
	logic [COMP_W-1:0]       out_comp_q;
	logic [CNT_OUT_W-1:0]    out_count_q;
	logic [MEAN_W-1:0]       out_mean_q;
	logic [FRAC_W-1:0]       out_frac_q;
	logic                    out_zero_q;
	logic                    out_ovf_q;
	logic                    out_last_q;

	logic [NCOMP_W-1:0]      n_use;
	logic                    vac_used;
	logic                    is_vac;
	logic                    k_last;
	logic                    need_frac;
	logic [COMP_W-1:0]       rd_idx;
	logic [COUNT_WIDTH-1:0]  cnt_rd;
	logic [31:0]             cnt_wide;
	logic                    out_free;
	logic                    out_load;

	always_comb begin
		if (cfg.ncomp == '0) begin
			n_use = NCOMP_W'(1);
		end else if (cfg.ncomp > NCOMP_W'(COMP_CAP)) begin
			n_use = NCOMP_W'(COMP_CAP);
		end else begin
			n_use = cfg.ncomp;
		end
	end

	assign vac_used  = cfg.vac_en && ({1'b0, cfg.vac_comp} < n_use);
	assign is_vac    = vac_used && (k_q == cfg.vac_comp);
	assign k_last    = (({1'b0, k_q} + NCOMP_W'(1)) == n_use);
	assign need_frac = (total_q != '0) && !is_vac;
	// one read port: site component while counting, sweep index otherwise
	assign rd_idx    = (st_q == BK_IDLE) ? q_data.comp : k_q;
	assign cnt_rd    = counts_q[rd_idx];
	assign cnt_wide  = 32'(cnt_rd);
	assign out_free  = !out_valid_q || results.ready;

	assign div_num = {cnt_rd, {FRAC_BITS{1'b0}}};
	assign div_den = (st_q == BK_MEAN_GO) ? DEN_W'(vol_of(cfg)) : DEN_W'(total_q);

	always_comb begin
		st_d      = st_q;
		pop       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (q_data.final_site) begin
						st_d = BK_SUM;
					end
				end
			end
			BK_SUM: begin
				if (k_last) begin
					st_d = BK_MEAN_GO;
				end
			end
			BK_MEAN_GO: begin
				div_start = 1'b1;
				st_d      = BK_MEAN_WAIT;
			end
			BK_MEAN_WAIT: begin
				if (div_done) begin
					st_d = need_frac ? BK_FRAC_GO : BK_PUSH;
				end
			end
			BK_FRAC_GO: begin
				div_start = 1'b1;
				st_d      = BK_FRAC_WAIT;
			end
			BK_FRAC_WAIT: begin
				if (div_done) begin
					st_d = BK_PUSH;
				end
			end
			BK_PUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d     = k_last ? BK_IDLE : BK_MEAN_GO;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				counts_q[i] <= '0;
			end
			k_q     <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (st_q)
				BK_IDLE: begin
					if (pop) begin
						if (q_data.counted) begin
							if (cnt_rd == COUNT_MAX) begin
								ovf_q <= 1'b1;
							end else begin
								counts_q[q_data.comp] <= cnt_rd + COUNT_WIDTH'(1);
							end
						end
						if (q_data.past) begin
							ovf_q <= 1'b1;
						end
						if (q_data.final_site) begin
							k_q     <= '0;
							total_q <= '0;
						end
					end
				end
				BK_SUM: begin
					if (!is_vac) begin
						total_q <= total_q + TOT_W'(cnt_rd);
					end
					k_q <= k_last ? '0 : k_q + COMP_W'(1);
				end
				BK_PUSH: begin
					if (out_load) begin
						if (k_last) begin
							for (int i = 0; i < STORE_DEPTH; i++) begin
								counts_q[i] <= '0;
							end
							ovf_q <= 1'b0;
							k_q   <= '0;
						end else begin
							k_q <= k_q + COMP_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_MEAN_WAIT && div_done) begin
			mean_q <= (div_quot > NUM_W'(24'hFFFFFF)) ? '1 : div_quot[MEAN_W-1:0];
			frac_q <= '0;
		end
		if (st_q == BK_FRAC_WAIT && div_done) begin
			frac_q <= div_quot[FRAC_W-1:0];
		end
		if (out_load) begin
			out_comp_q  <= k_q;
			out_count_q <= (cnt_wide > 32'hFFFF) ? '1 : cnt_wide[CNT_OUT_W-1:0];
			out_mean_q  <= mean_q;
			out_frac_q  <= frac_q;
			out_zero_q  <= (total_q == '0);
			out_ovf_q   <= ovf_q;
			out_last_q  <= k_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.component     = out_comp_q;
	assign results.count         = out_count_q;
	assign results.mean_per_cell = out_mean_q;
	assign results.fraction      = out_frac_q;
	assign results.zero_total    = out_zero_q;
	assign results.overflow      = out_ovf_q;
	assign results.last_result   = out_last_q;
endmodule

@@ verif/site_composition_counter_tb.sv @@
// self-checking testbench for site_composition_counter: directed and random site streams
// depends on scc_pkg, scc_in_if/scc_out_if and the rtl of the block
module site_composition_counter_tb;
	import scc_pkg::*;

	localparam int COUNT_MAX     = 65535;
	localparam int SETTLE_CYCLES = 200;
	localparam int MEAN_MAX      = 24'hFFFFFF;

	typedef struct packed {
		logic [OCC_W-1:0] occupant;
		logic             final_site;
	} site_beat_t;

	typedef struct packed {
		logic [COMP_W-1:0]    component;
		logic [CNT_OUT_W-1:0] count;
		logic [MEAN_W-1:0]    mean_per_cell;
		logic [FRAC_W-1:0]    fraction;
		logic                 zero_total;
		logic                 overflow;
		logic                 last_result;
	} composition_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scc_in_if  site_bus ();
	scc_out_if result_bus ();

	site_composition_counter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sites     (site_bus),
		.results   (result_bus),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies and run state of the composition model
	logic [MAP_W-1:0]   map_reg [NUM_MAPS];
	logic [VOL_W-1:0]   volume_reg;
	logic [NCOMP_W-1:0] ncomp_reg;
	logic               vac_en_reg;
	logic [COMP_W-1:0]  vac_comp_reg;
	int                 tally [STORE_DEPTH];
	int                 site_pos;
	int                 block_idx;
	bit                 flagged;

	site_beat_t   site_backlog [$];
	composition_t pending_results [$];

	int sites_total;
	int sites_sent;
	int runs_done;
	int beats_checked;
	int settings_used;
	int errors;
	int send_idle_pct;
	int recv_stall_pct;

	task automatic clear_run();
		foreach (tally[i]) tally[i] = 0;
		site_pos  = 0;
		block_idx = 0;
		flagged   = 1'b0;
	endtask

	// one accepted site: classify, count, and on the final site emit the composition
	task automatic count_site(input logic [OCC_W-1:0] occ, input logic fin);
		int           vol;
		int           n;
		int           comp;
		longint       total;
		longint       c;
		longint       mean;
		longint       frac;
		bit           vac_used;
		composition_t r;
		vol = (volume_reg == '0) ? 1 : int'(volume_reg);
		if (block_idx < NUM_MAPS) begin
			comp = int'((map_reg[block_idx] >> (3 * int'(occ))) & 7);
			if (tally[comp] >= COUNT_MAX)
				flagged = 1'b1;
			else
				tally[comp]++;
			site_pos++;
			if (site_pos >= vol) begin
				site_pos = 0;
				block_idx++;
			end
		end else begin
			flagged = 1'b1;
		end
		if (fin) begin
			n = int'(ncomp_reg);
			if (n == 0) n = 1;
			if (n > STORE_DEPTH) n = STORE_DEPTH;
			vac_used = vac_en_reg && (int'(vac_comp_reg) < n);
			total = 0;
			for (int k = 0; k < n; k++)
				if (!(vac_used && k == int'(vac_comp_reg))) total += tally[k];
			for (int k = 0; k < n; k++) begin
				c = tally[k];
				mean = (c << 16) / vol;
				if (mean > MEAN_MAX) mean = MEAN_MAX;
				frac = 0;
				if (total != 0 && !(vac_used && k == int'(vac_comp_reg)))
					frac = (c << 16) / total;
				r.component     = COMP_W'(k);
				r.count         = CNT_OUT_W'(c);
				r.mean_per_cell = MEAN_W'(mean);
				r.fraction      = FRAC_W'(frac);
				r.zero_total    = (total == 0);
				r.overflow      = flagged;
				r.last_result   = (k == n - 1);
				pending_results.push_back(r);
			end
			runs_done++;
			clear_run();
		end
	endtask

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// site driver
	always @(posedge clk) begin : site_driver
		site_beat_t beat;
		if (!arst_n) begin
			site_bus.valid      <= 1'b0;
			site_bus.occupant   <= '0;
			site_bus.final_site <= 1'b0;
		end else begin
			if (site_bus.valid && site_bus.ready) begin
				count_site(site_bus.occupant, site_bus.final_site);
				sites_sent++;
			end
			if (!site_bus.valid || site_bus.ready) begin
				if (site_backlog.size() > 0 && !chance(send_idle_pct)) begin
					beat = site_backlog.pop_front();
					site_bus.valid      <= 1'b1;
					site_bus.occupant   <= beat.occupant;
					site_bus.final_site <= beat.final_site;
				end else begin
					site_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		composition_t got;
		composition_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				got.component     = result_bus.component;
				got.count         = result_bus.count;
				got.mean_per_cell = result_bus.mean_per_cell;
				got.fraction      = result_bus.fraction;
				got.zero_total    = result_bus.zero_total;
				got.overflow      = result_bus.overflow;
				got.last_result   = result_bus.last_result;
				if (pending_results.size() == 0) begin
					if (errors < 10)
						$display("result beat %0d arrived with nothing expected", beats_checked);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						if (errors < 10) begin
							$display("result beat %0d: want comp %0d count %0d mean %h frac %h zt %b ovf %b last %b",
								beats_checked, want.component, want.count, want.mean_per_cell,
								want.fraction, want.zero_total, want.overflow, want.last_result);
							$display("                 got  comp %0d count %0d mean %h frac %h zt %b ovf %b last %b",
								got.component, got.count, got.mean_per_cell,
								got.fraction, got.zero_total, got.overflow, got.last_result);
						end
						errors++;
					end
				end
				beats_checked++;
			end
			result_bus.ready <= !chance(recv_stall_pct);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MAP0:     map_reg[0]   = val;
			REG_MAP1:     map_reg[1]   = val;
			REG_MAP2:     map_reg[2]   = val;
			REG_MAP3:     map_reg[3]   = val;
			REG_SITES:    volume_reg   = val[VOL_W-1:0];
			REG_NCOMP:    ncomp_reg    = val[NCOMP_W-1:0];
			REG_VAC_EN:   vac_en_reg   = val[0];
			REG_VAC_COMP: vac_comp_reg = val[COMP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [MAP_W-1:0] m0, input logic [MAP_W-1:0] m1,
		input logic [MAP_W-1:0] m2, input logic [MAP_W-1:0] m3, input logic [VOL_W-1:0] sps,
		input logic [NCOMP_W-1:0] nc, input logic ve, input logic [COMP_W-1:0] vc);
		write_reg(REG_MAP0, m0);
		write_reg(REG_MAP1, m1);
		write_reg(REG_MAP2, m2);
		write_reg(REG_MAP3, m3);
		write_reg(REG_SITES, CFG_DATA_W'(sps));
		write_reg(REG_NCOMP, CFG_DATA_W'(nc));
		write_reg(REG_VAC_EN, CFG_DATA_W'(ve));
		write_reg(REG_VAC_COMP, CFG_DATA_W'(vc));
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	task automatic push_site(input int occ, input bit fin);
		site_beat_t beat;
		beat.occupant   = OCC_W'(occ);
		beat.final_site = fin;
		site_backlog.push_back(beat);
		sites_total++;
	endtask

	// every queued beat accepted and every expected result seen
	task automatic wait_drain();
		while (sites_sent != sites_total || pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int idle_s, input int idle_r);
		logic [VOL_W-1:0] sps;
		int               cap;
		int               len;
		int               items;
		bit               paused;
		send_idle_pct  = idle_s;
		recv_stall_pct = idle_r;
		case ($urandom_range(0, 7))
			0:       sps = '0;
			1:       sps = '1;
			default: sps = VOL_W'($urandom_range(1, 6));
		endcase
		apply_settings(MAP_W'($urandom), MAP_W'($urandom), MAP_W'($urandom), MAP_W'($urandom),
			sps, NCOMP_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			COMP_W'($urandom_range(0, 7)));
		cap    = 4 * ((sps == '0) ? 1 : int'(sps));
		items  = 0;
		paused = 0;
		while (items < 10) begin
			if (sps > 8) begin
				len = $urandom_range(1, 8);
			end else begin
				case ($urandom_range(0, 9))
					0, 1:    len = $urandom_range(1, cap);
					2:       len = cap + $urandom_range(1, 3);
					default: len = cap;
				endcase
			end
			for (int j = 0; j < len; j++)
				push_site($urandom_range(0, 7), j == len - 1);
			items += len;
			// hold the sender until the block has drained its results
			if (!paused && items >= 5) begin
				wait_drain();
				paused = 1;
			end
		end
		settle();
	endtask

	initial begin : stimulus
		cfg_write        = 1'b0;
		cfg_index        = REG_MAP0;
		cfg_data         = '0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		foreach (map_reg[i]) map_reg[i] = '0;
		volume_reg   = VOL_W'(1);
		ncomp_reg    = NCOMP_W'(1);
		vac_en_reg   = 1'b0;
		vac_comp_reg = '0;
		clear_run();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// identity, reversed, all-seven and all-zero tables; a fifth block runs past the end
		apply_settings(24'o76543210, 24'o01234567, 24'o77777777, 24'o00000000,
			VOL_W'(2), NCOMP_W'(8), 1'b0, COMP_W'(0));
		push_site(0, 0); push_site(7, 0);
		push_site(7, 0); push_site(0, 0);
		push_site(3, 0); push_site(4, 0);
		push_site(1, 0); push_site(2, 0);
		push_site(5, 1);
		push_site(7, 1);
		settle();

		// zero volume, vacancy in use, vacancy-only and out-of-use runs
		apply_settings(24'o76543210, 24'o76543210, 24'o22222222, 24'o76543210,
			VOL_W'(0), NCOMP_W'(4), 1'b1, COMP_W'(2));
		push_site(0, 0); push_site(1, 0); push_site(2, 0); push_site(3, 1);
		push_site(2, 1);
		push_site(5, 1);
		push_site(0, 0); push_site(1, 0); push_site(2, 0); push_site(3, 0); push_site(4, 1);
		settle();

		// component count zero acts as one; vacancy index beyond it is ignored
		apply_settings(24'o76543210, MAP_W'($urandom), MAP_W'($urandom), MAP_W'($urandom),
			VOL_W'(1), NCOMP_W'(0), 1'b1, COMP_W'(3));
		push_site(3, 0); push_site(0, 1);
		settle();

		// component count above the store depth
		apply_settings(MAP_W'($urandom), MAP_W'($urandom), MAP_W'($urandom), MAP_W'($urandom),
			VOL_W'(2), NCOMP_W'(15), 1'b0, COMP_W'(7));
		for (int j = 0; j < 8; j++) push_site($urandom_range(0, 7), j == 7);
		settle();

		// widest volume, a short run inside the first sublattice block
		apply_settings('0, '0, '0, '0, '1, NCOMP_W'(2), 1'b0, COMP_W'(0));
		for (int j = 0; j < 12; j++) push_site($urandom_range(0, 7), j == 11);
		settle();

		for (int p = 0; p < 2; p++) begin
			random_phase(0, 0);
			random_phase(59, 0);
			random_phase(0, 59);
			random_phase(15, 15);
		end

		settle();
		errors += pending_results.size();
		$display("run covered %0d site beats in %0d runs, %0d result beats checked",
			sites_sent, runs_done, beats_checked);
		$display("over %0d register settings with idle and stall mixes on both channels",
			settings_used);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/scc_pkg.sv
rtl/core/scc_if.sv
rtl/core/scc_queue.sv
rtl/core/scc_front.sv
rtl/core/scc_div.sv
rtl/core/scc_back.sv
rtl/core/site_composition_counter.sv
verif/site_composition_counter_tb.sv
